// File: rtl/bpsk_framer_modulator_defines.svh
// Assertion macros shared by the framer RTL. Both sample on clk and are
// switched off while rst_n is low.
`ifndef BPSK_FRAMER_MODULATOR_DEFINES_SVH
`define BPSK_FRAMER_MODULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bfm_pkg.sv
`default_nettype none

package bfm_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned GAIN_W   = 6;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [GAIN_W-1:0]  GAIN_RESET     = 6'd10;
  localparam logic [COUNT_W-1:0] INTERVAL_RESET = 8'd100;

  // Sync word +1,+1,+1,-1,+1,-1,-1,+1, first symbol in bit 0.
  localparam logic [7:0] SYNC_WORD = 8'h97;
  localparam int unsigned DATA_LSB = 23;

  localparam logic [3:0] SLOT_RESET = 4'd8;
  localparam logic [9:0] CARRIER_AMP = 10'd1000;
  localparam logic [OUT_W-1:0] OUT_LIMIT = 16'd32767;

  // Carrier table index codes with a nonzero entry.
  localparam logic [1:0] PHASE_PEAK   = 2'd1;
  localparam logic [1:0] PHASE_TROUGH = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_GAIN = 2'd0,
    REG_SYNC_PERIOD = 2'd1
  } cfg_reg_t;

  // One word between the framer and the output stage.
  typedef struct packed {
    logic       positive;
    logic [1:0] phase;
  } sym_t;

endpackage

`default_nettype wire

// File: rtl/bfm_framer.sv
`default_nettype none

module bfm_framer
  import bfm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [COUNT_W-1:0]  sync_period,
  input  wire logic                down_ready,
  output logic                     sym_valid,
  output sym_t                     sym
);

`include "bpsk_framer_modulator_defines.svh"

  logic [2:0]         phase_r, phase_nxt;
  logic [3:0]         slot_r, slot_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         symbols_r, symbols_nxt;
  logic               sym_valid_r, sym_valid_nxt;
  sym_t               sym_r, sym_nxt;
  logic               accept;
  logic               load;
  logic [3:0]         slot_step;

  assign in_stall = sym_valid_r && !down_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    slot_step   = phase_r[2] ? slot_r + 4'd1 : slot_r;
    load        = slot_step[3];
    slot_nxt    = load ? 4'd0 : slot_step;
    count_nxt   = count_r;
    symbols_nxt = symbols_r;
    if (load) begin
      if (count_r >= sync_period) begin
        count_nxt   = '0;
        symbols_nxt = SYNC_WORD;
      end else begin
        count_nxt   = count_r + 8'd1;
        symbols_nxt = in_sample[DATA_LSB +: 8];
      end
    end
    sym_nxt.positive = symbols_nxt[slot_nxt[2:0]];
    sym_nxt.phase    = phase_r[2] ? 2'd0 : phase_r[1:0];
    phase_nxt        = {1'b0, sym_nxt.phase} + 3'd1;
    sym_valid_nxt    = accept || (sym_valid_r && !down_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      slot_r      <= SLOT_RESET;
      count_r     <= '0;
      symbols_r   <= '0;
      sym_valid_r <= 1'b0;
    end else begin
      sym_valid_r <= sym_valid_nxt;
      if (accept) begin
        phase_r   <= phase_nxt;
        slot_r    <= slot_nxt;
        count_r   <= count_nxt;
        symbols_r <= symbols_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_r <= sym_nxt;
    end
  end

  assign sym_valid = sym_valid_r;
  assign sym       = sym_r;

  `BFM_ASSERT_NOW(a_slot_reset_state, slot_r == SLOT_RESET, (phase_r == 3'd0) && (count_r == '0), "forced frame load seen outside the reset state")
  `BFM_ASSERT_NEXT(a_sync_clears_count, accept && load && (count_r >= sync_period), (count_r == '0) && (symbols_r == SYNC_WORD), "sync frame did not clear the frame count")
  `BFM_ASSERT_NEXT(a_hold_when_blocked, sym_valid_r && !down_ready, sym_valid_r && $stable(sym_r), "pending symbol word lost while output stage was full")

endmodule

`default_nettype wire

// File: rtl/bfm_shaper.sv
`default_nettype none

module bfm_shaper
  import bfm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    sym_valid,
  input  wire sym_t                    sym,
  input  wire logic [GAIN_W-1:0]       gain,
  output logic                         ready,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      out_carrier,
  output logic signed [OUT_W-1:0]      out_modulated
);

`include "bpsk_framer_modulator_defines.svh"

  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] carrier_r, carrier_nxt;
  logic signed [OUT_W-1:0] modulated_r, modulated_nxt;
  logic [OUT_W-1:0]        product;
  logic [OUT_W-1:0]        amp;
  logic                    load;

  assign ready = !out_valid_r || !out_stall;
  assign load  = sym_valid && ready;

  always_comb begin
    // 63 * 1000 still fits in 16 unsigned bits; clamp to the signed limit.
    product = {10'd0, gain} * {6'd0, CARRIER_AMP};
    amp     = (product > OUT_LIMIT) ? OUT_LIMIT : product;
    unique case (sym.phase)
      PHASE_PEAK:   carrier_nxt = signed'(amp);
      PHASE_TROUGH: carrier_nxt = -signed'(amp);
      default:      carrier_nxt = '0;
    endcase
    modulated_nxt = sym.positive ? carrier_nxt : -carrier_nxt;
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      carrier_r   <= carrier_nxt;
      modulated_r <= modulated_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_carrier   = carrier_r;
  assign out_modulated = modulated_r;

  `BFM_ASSERT_NOW(a_same_magnitude, out_valid_r, (modulated_r == carrier_r) || (modulated_r == -carrier_r), "modulated word differs from carrier in magnitude")
  `BFM_ASSERT_NOW(a_within_limit, out_valid_r, (carrier_r <= signed'(OUT_LIMIT)) && (carrier_r >= -signed'(OUT_LIMIT)), "carrier word outside the clamp range")
  `BFM_ASSERT_NEXT(a_word_taken, load, out_valid_r, "symbol word accepted but no result word presented")

endmodule

`default_nettype wire

// File: rtl/bpsk_framer_modulator.sv
// A word accepted at a clock edge is registered in the framer symbol register, then in the
// output register that drives out_*. Throughput: one word per cycle while out_stall is low;
// framer register and output register form a two-deep pipeline, so one more word is taken
// while a result waits under out_stall.
// Reset (rst_n low at a clock edge): output_gain 10, sync period 100, carrier phase 0,
// frame count 0, and the first accepted word starts a new frame.
`default_nettype none

module bpsk_framer_modulator
  import bfm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel: one filtered sample per word.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_filtered_sample,
  // Result channel: carrier and BPSK sample per word.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [OUT_W-1:0]     out_carrier_out,
  output logic signed [OUT_W-1:0]     out_modulated_out,
  // Configuration write channel.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [GAIN_W-1:0]  gain_r;
  logic [COUNT_W-1:0] interval_r;
  logic               sym_valid;
  sym_t               sym;
  logic               shaper_ready;

  // Registers are always writable; the write takes effect at the edge.
  assign cfg_ready = 1'b1;

  // Indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OUTPUT_GAIN: gain_r     <= cfg_data[GAIN_W-1:0];
        REG_SYNC_PERIOD: interval_r <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The framer tracks carrier phase, symbol slot and frame count, loads a
  // sync word or eight data bits at each frame start, and registers the
  // current symbol sign together with the carrier table index.
  bfm_framer u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_filtered_sample),
    .sync_period   (interval_r),
    .down_ready    (shaper_ready),
    .sym_valid     (sym_valid),
    .sym           (sym)
  );

  // The shaper scales the carrier by the gain, clamps it, applies the
  // symbol sign and holds the result in the output register.
  bfm_shaper u_shaper (
    .clk           (clk),
    .rst_n         (rst_n),
    .sym_valid     (sym_valid),
    .sym           (sym),
    .gain          (gain_r),
    .ready         (shaper_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_carrier   (out_carrier_out),
    .out_modulated (out_modulated_out)
  );

endmodule

`default_nettype wire
